// File: rtl/assert_macros.svh
// Assertion helpers for the checker file psl_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSL_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PSL_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/psl_pkg.sv
package psl_pkg;

  typedef enum logic {
    CMD_CHECK = 1'b0,
    CMD_ADD   = 1'b1
  } cmd_e;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CONN  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SEC = 1'd1;

  localparam logic [15:0] MAX_CONN_RST  = 16'd10;
  localparam logic [19:0] BLOCK_SEC_RST = 20'd600;

  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] src_addr;
    logic [31:0] now_seconds;
  } req_t;

  typedef struct packed {
    logic        blocked;
    logic        present;
    logic [15:0] conn_count;
    logic        table_full;
  } rsp_t;

  typedef struct packed {
    logic [15:0] max_connections;
    logic [19:0] block_seconds;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] addr;
    logic [15:0] count;
    logic [31:0] stamp;
  } entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SWEEP,
    ST_TAIL,
    ST_FINISH
  } state_e;

endpackage

// File: rtl/psl_stream_if.sv
interface psl_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/per_source_connection_limiter_top.sv
// Channel   Direction  Payload                                       Handshake
// req_i     in         cmd, src_addr, now_seconds                    valid/ready
// rsp_o     out        blocked, present, conn_count, table_full      valid/ready
// cfg       in         cfg_we_i, cfg_idx_i, cfg_data_i               write enable only
//
// For each transaction the controller reads every table entry once through
// the single read port of the table memory, one entry per cycle, then, on an
// add, writes the result. After reset a clearing pass marks every entry
// free; no request is accepted during it, but configuration writes are taken.
// A stalled response sits in the output register while the next request is
// already being accepted and swept.
module per_source_connection_limiter_top #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  psl_stream_if.sink                         req_i,
  psl_stream_if.source                       rsp_o,
  input  logic                               cfg_we_i,
  input  logic [psl_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [psl_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import psl_pkg::*;

  localparam int unsigned IdxW = $clog2(TABLE_ENTRIES);

  cfg_t             cfg_q;
  logic             mem_we;
  logic [IdxW-1:0]  mem_waddr;
  entry_t           mem_wdata;
  logic             mem_re;
  logic [IdxW-1:0]  mem_raddr;
  entry_t           mem_rdata;

  // Configuration registers. Writes must arrive only while no transaction is in
  // flight; the block does not enforce this. The controller reads them directly.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_connections <= MAX_CONN_RST;
      cfg_q.block_seconds   <= BLOCK_SEC_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAX_CONN:  cfg_q.max_connections <= cfg_data_i[15:0];
        CFG_BLOCK_SEC: cfg_q.block_seconds   <= cfg_data_i;
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  // The controller sweeps the table, ages entries out on a check, tracks the
  // first matching and the first free entry, and writes back on an add.
  psl_ctrl #(
    .ENTRIES (TABLE_ENTRIES),
    .IDX_W   (IdxW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // Each table word holds the valid flag, address, count and time stamp.
  psl_table_mem #(
    .ENTRIES (TABLE_ENTRIES),
    .IDX_W   (IdxW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );
endmodule

// File: rtl/psl_table_mem.sv
module psl_table_mem #(
  parameter int unsigned ENTRIES = 64,
  parameter int unsigned IDX_W   = $clog2(ENTRIES)
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [IDX_W-1:0]    waddr_i,
  input  psl_pkg::entry_t     wdata_i,
  input  logic                re_i,
  input  logic [IDX_W-1:0]    raddr_i,
  output psl_pkg::entry_t     rdata_o
);
  import psl_pkg::*;

  entry_t mem [ENTRIES];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// File: rtl/psl_ctrl.sv
module psl_ctrl #(
  parameter int unsigned ENTRIES = 64,
  parameter int unsigned IDX_W   = $clog2(ENTRIES)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  psl_pkg::cfg_t       cfg_i,
  psl_stream_if.sink          req_i,
  psl_stream_if.source        rsp_o,
  output logic                mem_we_o,
  output logic [IDX_W-1:0]    mem_waddr_o,
  output psl_pkg::entry_t     mem_wdata_o,
  output logic                mem_re_o,
  output logic [IDX_W-1:0]    mem_raddr_o,
  input  psl_pkg::entry_t     mem_rdata_i
);
  import psl_pkg::*;

  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(ENTRIES - 1);

  state_e            state_q, state_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  req_t              req_q, req_d;
  logic              rvld_q;
  logic [IDX_W-1:0]  ridx_q;
  logic              found_q, found_d;
  logic [IDX_W-1:0]  found_idx_q, found_idx_d;
  logic [15:0]       found_cnt_q, found_cnt_d;
  logic              free_q, free_d;
  logic [IDX_W-1:0]  free_idx_q, free_idx_d;
  logic              rsp_valid_q, rsp_valid_d;
  rsp_t              rsp_q, rsp_d;

  logic [31:0]       age;
  logic              expired;
  logic              live;
  logic              load;
  logic [15:0]       next_cnt;

  // Age of the entry returned by the memory, taken modulo 2^32.
  assign age     = req_q.now_seconds - mem_rdata_i.stamp;
  assign expired = age > {12'd0, cfg_i.block_seconds};
  assign live    = mem_rdata_i.valid && ((req_q.cmd == CMD_ADD) || !expired);
  assign load    = (state_q == ST_FINISH) && (!rsp_valid_q || rsp_o.ready);
  assign next_cnt = found_cnt_q + 16'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      idx_q       <= '0;
      rvld_q      <= 1'b0;
      found_q     <= 1'b0;
      free_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      rvld_q      <= (state_q == ST_SWEEP);
      found_q     <= found_d;
      free_q      <= free_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    ridx_q      <= idx_q;
    found_idx_q <= found_idx_d;
    found_cnt_q <= found_cnt_d;
    free_idx_q  <= free_idx_d;
    rsp_q       <= rsp_d;
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    req_d       = req_q;
    found_d     = found_q;
    found_idx_d = found_idx_q;
    found_cnt_d = found_cnt_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    rsp_valid_d = rsp_valid_q;
    rsp_d       = rsp_q;
    req_i.ready = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = ridx_q;
    mem_wdata_o = mem_rdata_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = idx_q;

    if (rsp_valid_q && rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end

    // Result of the read issued in the previous cycle.
    if (rvld_q) begin
      if (req_q.cmd == CMD_CHECK && mem_rdata_i.valid && expired) begin
        mem_we_o          = 1'b1;
        mem_wdata_o.valid = 1'b0;
      end
      if (live && mem_rdata_i.addr == req_q.src_addr && !found_q) begin
        found_d     = 1'b1;
        found_idx_d = ridx_q;
        found_cnt_d = mem_rdata_i.count;
      end
      if (!mem_rdata_i.valid && !free_q) begin
        free_d     = 1'b1;
        free_idx_d = ridx_q;
      end
    end

    case (state_q)
      ST_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = idx_q;
        mem_wdata_o = '0;
        idx_d       = idx_q + 1'b1;
        if (idx_q == LastIdx) begin
          idx_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          req_d   = req_i.payload;
          found_d = 1'b0;
          free_d  = 1'b0;
          idx_d   = '0;
          state_d = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        mem_re_o = 1'b1;
        idx_d    = idx_q + 1'b1;
        if (idx_q == LastIdx) begin
          idx_d   = '0;
          state_d = ST_TAIL;
        end
      end
      ST_TAIL: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        rsp_d = '0;
        if (req_q.cmd == CMD_CHECK) begin
          rsp_d.present    = found_q;
          rsp_d.conn_count = found_q ? found_cnt_q : 16'd0;
          rsp_d.blocked    = found_q && (found_cnt_q >= cfg_i.max_connections);
        end else if (found_q) begin
          rsp_d.present    = 1'b1;
          rsp_d.conn_count = found_cnt_q;
          if (found_cnt_q < cfg_i.max_connections) begin
            rsp_d.conn_count  = next_cnt;
            mem_we_o          = load;
            mem_waddr_o       = found_idx_q;
            mem_wdata_o.valid = 1'b1;
            mem_wdata_o.addr  = req_q.src_addr;
            mem_wdata_o.count = next_cnt;
            mem_wdata_o.stamp = req_q.now_seconds;
          end
        end else if (free_q) begin
          rsp_d.conn_count  = 16'd1;
          mem_we_o          = load;
          mem_waddr_o       = free_idx_q;
          mem_wdata_o.valid = 1'b1;
          mem_wdata_o.addr  = req_q.src_addr;
          mem_wdata_o.count = 16'd1;
          mem_wdata_o.stamp = req_q.now_seconds;
        end else begin
          rsp_d.table_full = 1'b1;
        end
        if (load) begin
          rsp_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          rsp_d = rsp_q;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_q;
endmodule

// File: rtl/psl_checker.sv
`include "assert_macros.svh"

module psl_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           req_valid_i,
  input logic           req_ready_i,
  input logic           rsp_valid_i,
  input logic           rsp_ready_i,
  input psl_pkg::rsp_t  rsp_payload_i
);
  import psl_pkg::*;

  logic req_take;
  logic rsp_wait;
  logic rsp_blocked;
  logic rsp_full;
  logic rsp_dropped;

  // Handshake and payload conditions, named to keep the assertions short.
  assign req_take    = req_valid_i && req_ready_i;
  assign rsp_wait    = rsp_valid_i && !rsp_ready_i;
  assign rsp_blocked = rsp_valid_i && rsp_payload_i.blocked;
  assign rsp_full    = rsp_valid_i && rsp_payload_i.table_full;
  assign rsp_dropped = !rsp_payload_i.present && (rsp_payload_i.conn_count == 16'd0);

  `PSL_ASSERT_NXT(a_rsp_hold, clk_i, rst_ni, rsp_wait, rsp_valid_i)
  `PSL_ASSERT_NXT(a_rsp_stable, clk_i, rst_ni, rsp_wait, $stable(rsp_payload_i))
  `PSL_ASSERT_NXT(a_one_at_a_time, clk_i, rst_ni, req_take, !req_ready_i)
  `PSL_ASSERT_IMP(a_blocked_present, clk_i, rst_ni, rsp_blocked, rsp_payload_i.present)
  `PSL_ASSERT_IMP(a_full_dropped, clk_i, rst_ni, rsp_full, rsp_dropped)
endmodule

bind per_source_connection_limiter_top psl_checker u_psl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .rsp_payload_i (rsp_o.payload)
);
